@@ design/ordered_membership_toggle_table_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the ordered membership toggle table
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ORDERED_MEMBERSHIP_TOGGLE_TABLE_DEFINES_SVH
`define ORDERED_MEMBERSHIP_TOGGLE_TABLE_DEFINES_SVH

// Same-cycle implication.
`define OMTT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("omtt assertion failed");

// Next-cycle implication.
`define OMTT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("omtt assertion failed");

`endif

@@ design/omtt_pkg.sv @@
// ----------------------------------------------------------------------------
// omtt_pkg
// Shared types for the ordered membership toggle table.
// ----------------------------------------------------------------------------
`default_nettype none

package omtt_pkg;

  typedef enum logic [1:0] {
    REQ_TOGGLE = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_READ   = 2'd3
  } req_kind_t;

  typedef struct packed {
    req_kind_t   req_type;
    logic [15:0] station_id;
    logic [4:0]  entry_index;
  } req_t;

  typedef struct packed {
    logic        is_member;
    logic        changed;
    logic        full_reject;
    logic [5:0]  entry_count;
    logic [15:0] entry_value;
    logic        entry_valid;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture request beat
    logic step;        // issue next sweep read
    logic move;        // write previous read one slot down
    logic hit_shift;   // start compaction after the hit position
    logic append;      // write id at tail, count up
    logic dec;         // count down
    logic rd_idx;      // read entry at request index
    logic set_member;
    logic set_changed;
    logic set_reject;
    logic emit;        // load output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    req_kind_t kind;
    logic      hit;
    logic      sweep_end;
    logic      full;
    logic      out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ design/omtt_dp.sv @@
// ----------------------------------------------------------------------------
// omtt_dp
// Entry memory, count, sweep pointer, result flags and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module omtt_dp #(
  parameter int CAPACITY = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  omtt_pkg::req_t     in_data,
  input  omtt_pkg::cmd_t     cmd,
  output omtt_pkg::sts_t     sts,
  output logic               out_valid,
  input  wire logic          out_ready,
  output omtt_pkg::rsp_t     out_data
);
  import omtt_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int IW = (CW > 5) ? CW : 5;

  logic [15:0]   mem_r [CAPACITY];
  logic [15:0]   rdata_r;
  req_t          req_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] ptr_r;
  logic [CW-1:0] pos_r;
  logic          pend_r;
  logic          member_r;
  logic          changed_r;
  logic          reject_r;
  logic          out_valid_r;
  rsp_t          out_r;

  logic          more;
  logic          idx_ok;
  logic [IW-1:0] idx_w;
  logic [IW-1:0] cnt_w;
  logic [CW-1:0] pos_m1;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;
  logic          is_read;
  rsp_t          rsp;

  always_comb begin
    more    = ptr_r < count_r;
    idx_w   = IW'(req_r.entry_index);
    cnt_w   = IW'(count_r);
    idx_ok  = idx_w < cnt_w;
    pos_m1  = pos_r - CW'(1);
    rd_en   = (cmd.step && more && !cmd.hit_shift) || (cmd.rd_idx && idx_ok);
    rd_addr = cmd.rd_idx ? idx_w[AW-1:0] : ptr_r[AW-1:0];
    wr_en   = cmd.append || (cmd.move && pend_r);
    wr_addr = cmd.append ? count_r[AW-1:0] : pos_m1[AW-1:0];
    wr_data = cmd.append ? req_r.station_id : rdata_r;
    is_read = req_r.req_type == REQ_READ;

    sts.kind      = req_r.req_type;
    sts.hit       = pend_r && (rdata_r == req_r.station_id);
    sts.sweep_end = !pend_r && !more;
    sts.full      = count_r == CW'(CAPACITY);
    sts.out_free  = !out_valid_r || out_ready;

    rsp.is_member   = member_r;
    rsp.changed     = changed_r;
    rsp.full_reject = reject_r;
    rsp.entry_count = 6'(count_r);
    rsp.entry_valid = is_read && idx_ok;
    rsp.entry_value = (is_read && idx_ok) ? rdata_r : 16'd0;
  end

  // entry memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ptr_r       <= '0;
      pos_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        ptr_r  <= '0;
        pend_r <= 1'b0;
      end else if (cmd.hit_shift) begin
        // compaction starts with the entry just after the hit
        ptr_r  <= pos_r + CW'(1);
        pend_r <= 1'b0;
      end else if (cmd.step) begin
        pend_r <= more;
        if (more) begin
          ptr_r <= ptr_r + CW'(1);
          pos_r <= ptr_r;
        end
      end

      if (cmd.append) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.dec) begin
        count_r <= count_r - CW'(1);
      end

      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r     <= in_data;
      member_r  <= 1'b0;
      changed_r <= 1'b0;
      reject_r  <= 1'b0;
    end else begin
      if (cmd.set_member) begin
        member_r <= 1'b1;
      end
      if (cmd.set_changed) begin
        changed_r <= 1'b1;
      end
      if (cmd.set_reject) begin
        reject_r <= 1'b1;
      end
    end
    if (cmd.emit) begin
      out_r <= rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

@@ design/omtt_ctrl.sv @@
// ----------------------------------------------------------------------------
// omtt_ctrl
// Request sequencer: scan, compaction, append, read and result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module omtt_ctrl (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  omtt_pkg::sts_t sts,
  output omtt_pkg::cmd_t cmd
);
  import omtt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_READ,
    ST_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (sts.kind == REQ_READ) begin
          // reads skip the search
          state_nxt = ST_READ;
        end else if (sts.hit) begin
          if (sts.kind == REQ_TOGGLE) begin
            cmd.hit_shift = 1'b1;
            state_nxt     = ST_SHIFT;
          end else begin
            cmd.set_member = 1'b1;
            state_nxt      = ST_DONE;
          end
        end else if (sts.sweep_end) begin
          if (sts.kind == REQ_TOGGLE || sts.kind == REQ_ADD) begin
            if (sts.full) begin
              cmd.set_reject = 1'b1;
            end else begin
              cmd.append      = 1'b1;
              cmd.set_member  = 1'b1;
              cmd.set_changed = 1'b1;
            end
          end
          state_nxt = ST_DONE;
        end
      end
      ST_SHIFT: begin
        cmd.step = 1'b1;
        cmd.move = 1'b1;
        if (sts.sweep_end) begin
          cmd.dec         = 1'b1;
          cmd.set_changed = 1'b1;
          state_nxt       = ST_DONE;
        end
      end
      ST_READ: begin
        cmd.rd_idx = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/ordered_membership_toggle_table.sv @@
// ----------------------------------------------------------------------------
// ordered_membership_toggle_table
// Bounded insertion-ordered set of distinct 16-bit ids with compaction.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready/in_data carries one request beat: toggle,
// add-if-absent, query or read-by-index. Output channel out_valid/out_ready/
// out_data returns exactly one result beat per request, in order.
// One request is in flight at a time. A search reads one entry per cycle
// from the entry memory, which has one write and one read port. A toggle
// that removes an entry stops its search at the hit and then runs a
// compaction pass that moves every later entry one slot down.
// The result sits in an output register; in_ready is high again once it is
// loaded, so the next request is taken while the result waits. If the
// receiver stalls with a result still held, the next result waits in the
// sequencer until the register frees.
// Reset (rst_n low, synchronous) empties the set; no clearing pass is needed
// since only entries below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ordered_membership_toggle_table_defines.svh"

module ordered_membership_toggle_table #(
  parameter int CAPACITY = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  omtt_pkg::req_t in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output omtt_pkg::rsp_t out_data
);
  import omtt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  omtt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  omtt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // one request in flight: no accept in the cycle after an accept
  `OMTT_ASSERT_NEXT(a_single_flight, in_valid && in_ready, !in_ready)
  // result register is only loaded when free
  `OMTT_ASSERT_SAME(a_emit_free, cmd.emit, sts.out_free)
  // a read result never reports set changes
  `OMTT_ASSERT_SAME(a_read_clean, out_valid && out_data.entry_valid,
                    !out_data.changed && !out_data.full_reject && !out_data.is_member)
  // refusal only when the set is full
  `OMTT_ASSERT_SAME(a_reject_full, out_valid && out_data.full_reject,
                    out_data.entry_count == 6'(CAPACITY))

endmodule

`default_nettype wire

@@ tb/sv/ordered_membership_toggle_table_tb.sv @@
// ----------------------------------------------------------------------------
// ordered_membership_toggle_table_tb
// Self-checking bench for the bounded insertion-ordered id set. A behavioral
// copy of the set predicts every result beat at request accept time; a
// monitor compares each result beat against the oldest prediction. Both
// channels idle and stall at random, with back-to-back stretches in between.
// ----------------------------------------------------------------------------
module ordered_membership_toggle_table_tb;
  import omtt_pkg::*;

  localparam int CAPACITY    = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 2 * CAPACITY + 40;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  req_t in_data;
  logic out_valid;
  logic out_ready;
  rsp_t out_data;

  // behavioral copy of the set
  logic [15:0] held_ids [CAPACITY];
  int          held_count;

  rsp_t        pending_rsp[$];
  logic [15:0] id_pool [64];
  int          mismatches;
  int          cycle_count;
  int          ready_hold;
  bit          quiet;

  ordered_membership_toggle_table #(.CAPACITY(CAPACITY)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int draw_gap();
    if (quiet || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  function automatic int held_position(logic [15:0] id);
    for (int i = 0; i < held_count; i++) begin
      if (held_ids[i] == id) return i;
    end
    return -1;
  endfunction

  // Updates the set copy for one request and returns the result it causes.
  function automatic rsp_t apply_request(req_t r);
    rsp_t rsp;
    int   pos;
    rsp = '0;
    pos = held_position(r.station_id);
    case (r.req_type)
      REQ_TOGGLE, REQ_ADD: begin
        if (pos >= 0) begin
          if (r.req_type == REQ_TOGGLE) begin
            // close the gap
            for (int j = pos + 1; j < held_count; j++) held_ids[j - 1] = held_ids[j];
            held_count--;
            rsp.changed = 1'b1;
          end else begin
            rsp.is_member = 1'b1;
          end
        end else if (held_count < CAPACITY) begin
          held_ids[held_count] = r.station_id;
          held_count++;
          rsp.is_member = 1'b1;
          rsp.changed   = 1'b1;
        end else begin
          rsp.full_reject = 1'b1;
        end
      end
      REQ_QUERY: rsp.is_member = (pos >= 0);
      default: begin
        if (r.entry_index < held_count) begin
          rsp.entry_value = held_ids[r.entry_index];
          rsp.entry_valid = 1'b1;
        end
      end
    endcase
    rsp.entry_count = held_count[5:0];
    return rsp;
  endfunction

  // Called at a falling edge; returns at the falling edge after the accept.
  task automatic send_req(req_kind_t kind, logic [15:0] id, logic [4:0] idx);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid             = 1'b1;
    in_data.req_type     = kind;
    in_data.station_id   = id;
    in_data.entry_index  = idx;
    do @(posedge clk); while (!in_ready);
    pending_rsp.push_back(apply_request(in_data));
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(string name, logic [15:0] exp_val, logic [15:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, got_val);
      mismatches++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (rst_n && out_valid && out_ready) begin
      ready_hold = draw_gap();
      if (pending_rsp.size() == 0) begin
        $error("result beat with no request pending");
        mismatches++;
      end else begin
        exp_rsp = pending_rsp.pop_front();
        check_field("is_member",   16'(exp_rsp.is_member),   16'(out_data.is_member));
        check_field("changed",     16'(exp_rsp.changed),     16'(out_data.changed));
        check_field("full_reject", 16'(exp_rsp.full_reject), 16'(out_data.full_reject));
        check_field("entry_count", 16'(exp_rsp.entry_count), 16'(out_data.entry_count));
        check_field("entry_value", exp_rsp.entry_value,      out_data.entry_value);
        check_field("entry_valid", 16'(exp_rsp.entry_valid), 16'(out_data.entry_valid));
      end
    end
  end

  // receiver stall: hold ready low for the drawn count after each beat
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_ready = 1'b0;
      end else if (ready_hold > 0) begin
        out_ready = 1'b0;
        ready_hold--;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ordered_membership_toggle_table_tb: done, errors");
      $finish;
    end
  end

  task automatic reset_block();
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    held_count = 0;
    for (int i = 0; i < CAPACITY; i++) held_ids[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  endtask

  task automatic test_edges();
    send_req(REQ_READ,   16'h1234, 5'd0);    // read on empty set
    send_req(REQ_QUERY,  16'h0000, 5'd31);
    send_req(REQ_TOGGLE, 16'hFFFF, 5'd0);
    send_req(REQ_ADD,    16'h0000, 5'd31);
    send_req(REQ_ADD,    16'hFFFF, 5'd0);    // already present
    send_req(REQ_READ,   16'hFFFF, 5'd1);
    send_req(REQ_READ,   16'h0000, 5'd31);   // beyond count
    send_req(REQ_QUERY,  16'hFFFF, 5'd0);
    send_req(REQ_TOGGLE, 16'hFFFF, 5'd31);   // remove head, shift down
    send_req(REQ_READ,   16'h5A5A, 5'd0);
    send_req(REQ_TOGGLE, 16'h0000, 5'd0);    // back to empty
    send_req(REQ_QUERY,  16'h0000, 5'd0);
  endtask

  task automatic test_fill_and_overflow();
    logic [15:0] absent_id;
    while (held_count < CAPACITY) send_req(REQ_ADD, 16'($urandom), 5'($urandom));
    do absent_id = 16'($urandom); while (held_position(absent_id) >= 0);
    send_req(REQ_TOGGLE, absent_id, 5'd0);   // refused, set full
    send_req(REQ_ADD,    absent_id, 5'd0);   // refused, set full
    send_req(REQ_ADD,    held_ids[5], 5'd0);
    send_req(REQ_READ,   16'h0000, 5'd31);
    send_req(REQ_READ,   16'hFFFF, 5'd0);
    send_req(REQ_TOGGLE, held_ids[17], 5'd0);
    send_req(REQ_TOGGLE, held_ids[0], 5'd0);
    send_req(REQ_TOGGLE, held_ids[held_count - 1], 5'd0);
    send_req(REQ_READ,   16'h0000, 5'd30);
    send_req(REQ_READ,   16'h0000, 5'd28);
    send_req(REQ_TOGGLE, absent_id, 5'd0);   // room again
    send_req(REQ_QUERY,  absent_id, 5'd0);
  endtask

  task automatic run_random_phase(int n_items, int pool_n, int tog_pct, int add_pct,
                                  int qry_pct);
    int          roll;
    req_kind_t   kind;
    logic [15:0] id;
    logic [4:0]  idx;
    for (int i = 0; i < pool_n; i++) id_pool[i] = 16'($urandom);
    for (int n = 0; n < n_items; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < tog_pct) kind = REQ_TOGGLE;
      else if (roll < tog_pct + add_pct) kind = REQ_ADD;
      else if (roll < tog_pct + add_pct + qry_pct) kind = REQ_QUERY;
      else kind = REQ_READ;
      roll = $urandom_range(0, 9);
      if (roll == 0) id = 16'($urandom);
      else if (roll < 3 && held_count > 0) id = held_ids[$urandom_range(0, held_count - 1)];
      else id = id_pool[$urandom_range(0, pool_n - 1)];
      if (kind == REQ_READ && held_count > 0 && $urandom_range(0, 3) != 0)
        idx = 5'($urandom_range(0, held_count - 1));
      else
        idx = 5'($urandom_range(0, 31));
      send_req(kind, id, idx);
    end
  endtask

  task automatic test_toggle_churn();
    run_random_phase(300, 40, 50, 15, 15);
  endtask

  task automatic test_dedup_load();
    // pool larger than capacity, so the set sits full and refuses often
    run_random_phase(300, 48, 15, 55, 10);
  endtask

  task automatic test_sparse_set();
    run_random_phase(250, 6, 40, 10, 25);
  endtask

  task automatic test_back_to_back();
    quiet = 1'b1;
    run_random_phase(150, 36, 35, 25, 20);
    drain_results();
    quiet = 1'b0;
  endtask

  initial begin
    mismatches  = 0;
    cycle_count = 0;
    ready_hold  = 0;
    quiet       = 1'b0;
    reset_block();
    test_edges();
    drain_results();
    test_fill_and_overflow();
    drain_results();
    test_toggle_churn();
    drain_results();
    test_dedup_load();
    drain_results();
    test_back_to_back();
    test_sparse_set();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ordered_membership_toggle_table_tb: done, clean");
    end else begin
      $display("ordered_membership_toggle_table_tb: done, errors");
    end
    $finish;
  end

endmodule
